// ===== design/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion sampled on the rising clock edge, active during reset too.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ftpr_pkg.sv =====
// Types, constants and helpers shared by the FTP control reply parser.
package ftpr_pkg;

   localparam int SIZE_BITS = 48;
   localparam int SIZE_W    = SIZE_BITS + 4;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;

   localparam logic [15:0] LIMIT_RESET      = 16'd4096;
   localparam logic [15:0] COUNT_MAX        = 16'hFFFF;
   localparam logic [15:0] CODE_LENGTH      = 16'd3;
   localparam logic [15:0] SIZE_START_INDEX = 16'd4;
   localparam logic [1:0]  PREFIX_FULL      = 2'd3;
   localparam logic [9:0]  CODE_PASV        = 10'd227;
   localparam logic [9:0]  CODE_SIZE        = 10'd213;
   localparam logic [9:0]  GROUP_MAX        = 10'd255;
   localparam logic [1:0]  GROUP_DIGITS_MAX = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_CODE_BAD  = 2'd2;
   localparam logic [1:0] STATUS_TUPLE_BAD = 2'd3;

   localparam logic [2:0] PHASE_NONE      = 3'd0;
   localparam logic [2:0] PHASE_FIRST     = 3'd1;
   localparam logic [2:0] PHASE_LAST_ADDR = 3'd4;
   localparam logic [2:0] PHASE_PORT_HIGH = 3'd5;
   localparam logic [2:0] PHASE_PORT_LOW  = 3'd6;
   localparam logic [2:0] PHASE_CLOSED    = 3'd7;

   localparam logic [1:0] RUN_IDLE   = 2'd0;
   localparam logic [1:0] RUN_ACTIVE = 2'd1;
   localparam logic [1:0] RUN_ENDED  = 2'd2;
   localparam logic [1:0] RUN_NONE   = 2'd3;

   typedef struct packed {
      logic [2:0]  phase;
      logic [9:0]  value;
      logic [1:0]  digits;
      logic [31:0] address;
      logic [7:0]  port_high;
      logic        bad;
   } tuple_state_type;

   localparam tuple_state_type TUPLE_RESET = '{
      phase: PHASE_NONE, value: 10'd0, digits: 2'd0,
      address: 32'd0, port_high: 8'd0, bad: 1'b0};

   // Result fields, reply_code in the lowest bits.
   typedef struct packed {
      logic        size_valid;
      logic [47:0] byte_total;
      logic        address_valid;
      logic [15:0] pasv_port;
      logic [31:0] host_address;
      logic [1:0]  status;
      logic [9:0]  reply_code;
   } reply_type;

   localparam int REPLY_BITS = $bits(reply_type);
   localparam int RSP_BYTES  = (REPLY_BITS + 7) / 8;
   localparam int RSP_BITS   = RSP_BYTES * 8;

   function automatic logic is_digit(input logic [7:0] b);
      return b inside {[8'h30:8'h39]};
   endfunction

   function automatic logic [3:0] digit_value(input logic [7:0] b);
      logic [7:0] diff;
      diff = b - CHAR_ZERO;
      return diff[3:0];
   endfunction

endpackage

// ===== design/ftpr_tuple.sv =====
// Next-state logic for the passive-mode address tuple.
module ftpr_tuple
   import ftpr_pkg::*;
(
   input  tuple_state_type cur,
   input  logic [7:0]      rx_byte,
   output tuple_state_type nxt
);

   logic       digit;
   logic [9:0] value_next;

   assign digit      = is_digit(rx_byte);
   assign value_next = {cur.value[6:0], 3'b000} + {cur.value[8:0], 1'b0}
                       + 10'(digit_value(rx_byte));

   always_comb begin
      nxt = cur;
      if (cur.phase == PHASE_NONE) begin
         if (rx_byte == CHAR_OPEN) begin
            nxt.phase  = PHASE_FIRST;
            nxt.value  = 10'd0;
            nxt.digits = 2'd0;
         end
      end else if (cur.phase != PHASE_CLOSED) begin
         if (digit) begin
            if (cur.digits >= GROUP_DIGITS_MAX) begin
               nxt.bad   = 1'b1;
               nxt.phase = PHASE_CLOSED;
            end else begin
               nxt.value  = value_next;
               nxt.digits = cur.digits + 2'd1;
            end
         end else if (cur.digits == 2'd0 || cur.value > GROUP_MAX) begin
            nxt.bad   = 1'b1;
            nxt.phase = PHASE_CLOSED;
         end else if (rx_byte == CHAR_COMMA && cur.phase <= PHASE_PORT_HIGH) begin
            if (cur.phase <= PHASE_LAST_ADDR) begin
               nxt.address = {cur.address[23:0], cur.value[7:0]};
            end else begin
               nxt.port_high = cur.value[7:0];
            end
            nxt.phase  = cur.phase + 3'd1;
            nxt.value  = 10'd0;
            nxt.digits = 2'd0;
         end else if (rx_byte == CHAR_CLOSE && cur.phase == PHASE_PORT_LOW) begin
            nxt.phase = PHASE_CLOSED;
         end else begin
            nxt.bad   = 1'b1;
            nxt.phase = PHASE_CLOSED;
         end
      end
   end

endmodule

// ===== design/ftp_control_reply_parser.sv =====
// Top level of the FTP control reply parser.
// Takes one reply byte per word and returns one result word per finished reply (the first
// CR LF after a line opening with three digits and a space) or when the byte count reaches
// the reply limit written through csr_wdata. A byte can be taken every cycle; the only stall
// is a byte that finishes a reply while the previous result still waits on rsp_tready. The
// result word follows its last accepted byte: the byte is registered in in_byte_ff, handled
// by the code, line, tuple and size logic, and the result is registered in rsp_data_ff.
module ftp_control_reply_parser
   import ftpr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // rx_byte
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // reply_code, status, host_address, pasv_port, address_valid, byte_total, size_valid
   output logic [RSP_BITS-1:0] rsp_tdata,
   input  logic                csr_we,
   input  logic [15:0]         csr_wdata
);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic [15:0]          limit_ff;
   logic [15:0]          count_ff, count_in;
   logic                 line_start_ff, line_start_in;
   logic [1:0]           prefix_ff, prefix_in;
   logic                 final_seen_ff, final_seen_in;
   logic                 prev_cr_ff, prev_cr_in;
   logic [9:0]           code_ff, code_in;
   logic                 code_bad_ff, code_bad_in;
   tuple_state_type      tuple_ff, tuple_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [1:0]           run_ff, run_in;
   logic                 rsp_valid_ff;
   reply_type            rsp_data_ff, reply_in;

   logic                 digit;
   logic [3:0]           dval;
   logic [SIZE_W-1:0]    size_grown;
   logic [63:0]          size_wide;
   logic                 done;
   logic                 overflow;
   logic                 has_result;
   logic                 advance;
   logic [1:0]           status;
   logic                 addr_ok;
   logic                 size_ok;

   ftpr_tuple u_tuple (
      .cur     (tuple_ff),
      .rx_byte (in_byte_ff),
      .nxt     (tuple_in)
   );

   assign digit      = is_digit(in_byte_ff);
   assign dval       = digit_value(in_byte_ff);
   assign size_grown = SIZE_W'({size_ff, 3'b000}) + SIZE_W'({size_ff, 1'b0}) + SIZE_W'(dval);
   assign size_wide  = 64'(size_ff);

   always_comb begin
      code_in       = code_ff;
      code_bad_in   = code_bad_ff;
      line_start_in = line_start_ff;
      prefix_in     = prefix_ff;
      final_seen_in = final_seen_ff;
      size_in       = size_ff;
      run_in        = run_ff;

      if (count_ff < CODE_LENGTH) begin
         code_in = {code_ff[6:0], 3'b000} + {code_ff[8:0], 1'b0}
                   + (digit ? 10'(dval) : 10'd0);
         if (!digit) begin
            code_bad_in = 1'b1;
         end
      end

      if (line_start_ff && !final_seen_ff) begin
         if (prefix_ff < PREFIX_FULL && digit) begin
            prefix_in = prefix_ff + 2'd1;
         end else if (prefix_ff == PREFIX_FULL && in_byte_ff == CHAR_SPACE) begin
            final_seen_in = 1'b1;
            line_start_in = 1'b0;
         end else begin
            line_start_in = 1'b0;
         end
      end
      done       = final_seen_in && prev_cr_ff && in_byte_ff == CHAR_LF;
      prev_cr_in = in_byte_ff == CHAR_CR;
      if (in_byte_ff == CHAR_LF) begin
         line_start_in = 1'b1;
         prefix_in     = 2'd0;
      end

      if (count_ff == SIZE_START_INDEX) begin
         if (digit) begin
            size_in = SIZE_BITS'(dval);
            run_in  = RUN_ACTIVE;
         end else begin
            run_in = RUN_NONE;
         end
      end else if (count_ff > SIZE_START_INDEX && run_ff == RUN_ACTIVE) begin
         if (digit) begin
            if (size_grown > SIZE_W'({SIZE_BITS{1'b1}})) begin
               size_in = {SIZE_BITS{1'b1}};
            end else begin
               size_in = size_grown[SIZE_BITS-1:0];
            end
         end else begin
            run_in = RUN_ENDED;
         end
      end

      count_in = (count_ff < COUNT_MAX) ? count_ff + 16'd1 : count_ff;
      overflow = count_in >= limit_ff;

      if (code_bad_ff) begin
         status = STATUS_CODE_BAD;
      end else if (code_ff == CODE_PASV
                   && (tuple_ff.phase != PHASE_CLOSED || tuple_ff.bad)) begin
         status = STATUS_TUPLE_BAD;
      end else begin
         status = STATUS_OK;
      end
      addr_ok = status == STATUS_OK && code_ff == CODE_PASV;
      size_ok = status == STATUS_OK && code_ff == CODE_SIZE
                && run_ff != RUN_IDLE && run_ff != RUN_NONE;

      reply_in = '0;
      if (overflow) begin
         reply_in.reply_code = code_in;
         reply_in.status     = STATUS_OVERFLOW;
      end else begin
         reply_in.reply_code = code_ff;
         reply_in.status     = status;
         if (addr_ok) begin
            reply_in.host_address  = tuple_ff.address;
            reply_in.pasv_port     = {tuple_ff.port_high, tuple_ff.value[7:0]};
            reply_in.address_valid = 1'b1;
         end
         if (size_ok) begin
            reply_in.byte_total = size_wide[47:0];
            reply_in.size_valid = 1'b1;
         end
      end
   end

   assign has_result = overflow || done;
   assign advance    = in_valid_ff && (!has_result || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'(rsp_data_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && has_result)) begin
         count_ff      <= 16'd0;
         line_start_ff <= 1'b1;
         prefix_ff     <= 2'd0;
         final_seen_ff <= 1'b0;
         prev_cr_ff    <= 1'b0;
         code_ff       <= 10'd0;
         code_bad_ff   <= 1'b0;
         tuple_ff      <= TUPLE_RESET;
         size_ff       <= '0;
         run_ff        <= RUN_IDLE;
      end else if (advance) begin
         count_ff      <= count_in;
         line_start_ff <= line_start_in;
         prefix_ff     <= prefix_in;
         final_seen_ff <= final_seen_in;
         prev_cr_ff    <= prev_cr_in;
         code_ff       <= code_in;
         code_bad_ff   <= code_bad_in;
         tuple_ff      <= tuple_in;
         size_ff       <= size_in;
         run_ff        <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && has_result) begin
         rsp_data_ff <= reply_in;
      end
   end

endmodule

// ===== design/ftpr_checker.sv =====
// Port-level checks for the FTP control reply parser, bound to its top level.
`include "assert_macros.svh"

module ftpr_checker
   import ftpr_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata
);

   reply_type reply;

   assign reply = reply_type'(rsp_tdata[REPLY_BITS-1:0]);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result word changed while stalled")
   `ASSERT_CLK(a_addr_code, clock, reset, rsp_tvalid && reply.address_valid |-> reply.reply_code == CODE_PASV && reply.status == STATUS_OK, "address valid on a reply that is not a clean 227")
   `ASSERT_CLK(a_size_code, clock, reset, rsp_tvalid && reply.size_valid |-> reply.reply_code == CODE_SIZE && reply.status == STATUS_OK, "size valid on a reply that is not a clean 213")
   `ASSERT_CLK(a_overflow_empty, clock, reset, rsp_tvalid && reply.status == STATUS_OVERFLOW |-> reply.host_address == 32'd0 && reply.pasv_port == 16'd0 && reply.byte_total == 48'd0 && !reply.address_valid && !reply.size_valid, "overflow word carries parsed fields")
   `ASSERT_CLK_ALWAYS(a_reset_quiet, clock, $past(reset) && !reset |-> !rsp_tvalid, "result word shown straight after reset")

endmodule

bind ftp_control_reply_parser ftpr_checker u_ftpr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/reply_checker.sv =====
// Checker for the FTP control reply parser: predicts every result word and compares it.
module reply_checker
   import ftpr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RSP_BITS-1:0] rsp_tdata,
   input  logic                csr_we,
   input  logic [15:0]         csr_wdata,
   output int                  fail_count,
   output int                  pending,
   output int                  replies_checked,
   output int                  pasv_seen,
   output int                  sizes_seen,
   output int                  overflows_seen
);

   localparam logic [63:0] SIZE_CEILING = {64{1'b1}} >> (64 - SIZE_BITS);

   logic [15:0] limit_q;
   logic [15:0] byte_idx;
   logic        line_head;
   logic [2:0]  lead_digits;
   logic        last_line;
   logic        after_cr;
   logic [9:0]  code;
   logic [2:0]  paren_phase;
   logic [9:0]  grp_val;
   logic [1:0]  grp_len;
   logic [31:0] pasv_addr;
   logic [7:0]  pasv_port_hi;
   logic [63:0] size_val;
   logic        code_bad;
   logic        tuple_bad;
   logic [1:0]  size_run;
   reply_type   replies_due[$];

   function automatic logic digit_in(input logic [7:0] b);
      return b >= CHAR_ZERO && b <= CHAR_ZERO + 8'd9;
   endfunction

   function void restart_reply();
      byte_idx     = '0;
      line_head    = 1'b1;
      lead_digits  = '0;
      last_line    = 1'b0;
      after_cr     = 1'b0;
      code         = '0;
      paren_phase  = PHASE_NONE;
      grp_val      = '0;
      grp_len      = '0;
      pasv_addr    = '0;
      pasv_port_hi = '0;
      size_val     = '0;
      code_bad     = 1'b0;
      tuple_bad    = 1'b0;
      size_run     = RUN_IDLE;
   endfunction

   function void abandon_tuple();
      tuple_bad   = 1'b1;
      paren_phase = PHASE_CLOSED;
   endfunction

   function void parse_byte(input logic [7:0] b);
      logic [15:0] idx;
      logic        isdig;
      logic [3:0]  d;
      logic        done;
      reply_type   r;
      idx   = byte_idx;
      isdig = digit_in(b);
      d     = 4'(b - CHAR_ZERO);

      if (idx < CODE_LENGTH) begin
         code = 10'(code * 10 + (isdig ? d : 4'd0));
         if (!isdig) code_bad = 1'b1;
      end

      if (line_head && !last_line) begin
         if (lead_digits < PREFIX_FULL && isdig) begin
            lead_digits++;
         end else if (lead_digits == PREFIX_FULL && b == CHAR_SPACE) begin
            last_line = 1'b1;
            line_head = 1'b0;
         end else begin
            line_head = 1'b0;
         end
      end
      done     = last_line && after_cr && b == CHAR_LF;
      after_cr = (b == CHAR_CR);
      if (b == CHAR_LF) begin
         line_head   = 1'b1;
         lead_digits = '0;
      end

      if (paren_phase == PHASE_NONE) begin
         if (b == CHAR_OPEN) begin
            paren_phase = PHASE_FIRST;
            grp_val     = '0;
            grp_len     = '0;
         end
      end else if (paren_phase != PHASE_CLOSED) begin
         if (isdig) begin
            if (grp_len == GROUP_DIGITS_MAX) begin
               abandon_tuple();
            end else begin
               grp_val = 10'(grp_val * 10 + d);
               grp_len++;
            end
         end else if (grp_len == 0 || grp_val > GROUP_MAX) begin
            abandon_tuple();
         end else if (b == CHAR_COMMA && paren_phase <= PHASE_PORT_HIGH) begin
            if (paren_phase <= PHASE_LAST_ADDR) pasv_addr = {pasv_addr[23:0], grp_val[7:0]};
            else pasv_port_hi = grp_val[7:0];
            paren_phase++;
            grp_val = '0;
            grp_len = '0;
         end else if (b == CHAR_CLOSE && paren_phase == PHASE_PORT_LOW) begin
            paren_phase = PHASE_CLOSED;
         end else begin
            abandon_tuple();
         end
      end

      if (idx == SIZE_START_INDEX) begin
         if (isdig) begin
            size_val = 64'(d);
            size_run = RUN_ACTIVE;
         end else begin
            size_run = RUN_NONE;
         end
      end else if (idx > SIZE_START_INDEX && size_run == RUN_ACTIVE) begin
         if (isdig) begin
            if (size_val > (SIZE_CEILING - d) / 10) size_val = SIZE_CEILING;
            else size_val = size_val * 10 + d;
         end else begin
            size_run = RUN_ENDED;
         end
      end

      if (byte_idx != COUNT_MAX) byte_idx++;

      r            = '0;
      r.reply_code = code;
      if (byte_idx >= limit_q) begin
         r.status = STATUS_OVERFLOW;
         replies_due.push_back(r);
         restart_reply();
      end else if (done) begin
         if (code_bad) r.status = STATUS_CODE_BAD;
         else if (code == CODE_PASV && (paren_phase != PHASE_CLOSED || tuple_bad))
            r.status = STATUS_TUPLE_BAD;
         else r.status = STATUS_OK;
         if (r.status == STATUS_OK && code == CODE_PASV) begin
            r.host_address  = pasv_addr;
            r.pasv_port     = 16'({pasv_port_hi, 8'h00} + grp_val);
            r.address_valid = 1'b1;
         end
         if (r.status == STATUS_OK && code == CODE_SIZE &&
             (size_run == RUN_ACTIVE || size_run == RUN_ENDED)) begin
            r.byte_total = size_val[47:0];
            r.size_valid = 1'b1;
         end
         replies_due.push_back(r);
         restart_reply();
      end
   endfunction

   function void check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      if (reset) begin
         limit_q = LIMIT_RESET;
         restart_reply();
         replies_due.delete();
         fail_count      = 0;
         replies_checked = 0;
         pasv_seen       = 0;
         sizes_seen      = 0;
         overflows_seen  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = reply_type'(rsp_tdata[REPLY_BITS-1:0]);
            if (replies_due.size() == 0) begin
               $error("Result word %0h arrived with no reply outstanding.", got);
               fail_count++;
            end else begin
               want = replies_due.pop_front();
               check_field("reply_code", 64'(want.reply_code), 64'(got.reply_code));
               check_field("status", 64'(want.status), 64'(got.status));
               check_field("host_address", 64'(want.host_address), 64'(got.host_address));
               check_field("pasv_port", 64'(want.pasv_port), 64'(got.pasv_port));
               check_field("address_valid", 64'(want.address_valid),
                           64'(got.address_valid));
               check_field("byte_total", 64'(want.byte_total), 64'(got.byte_total));
               check_field("size_valid", 64'(want.size_valid), 64'(got.size_valid));
               replies_checked++;
               if (want.address_valid) pasv_seen++;
               if (want.size_valid) sizes_seen++;
               if (want.status == STATUS_OVERFLOW) overflows_seen++;
            end
         end
         if (csr_we) limit_q = csr_wdata;
         if (req_tvalid && req_tready) parse_byte(req_tdata);
      end
      pending <= replies_due.size();
   end

endmodule

// ===== tb/testbench.sv =====
// Testbench top for the FTP control reply parser: drives reply bytes and gives the verdict.
module testbench;
   import ftpr_pkg::*;

   localparam int IDLE_LIMIT = 2000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata = 8'h00;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b1;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic                csr_we = 1'b0;
   logic [15:0]         csr_wdata = 16'h0000;

   int fail_count;
   int pending;
   int replies_checked;
   int pasv_seen;
   int sizes_seen;
   int overflows_seen;
   int bytes_sent = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;

   always #5 clock = ~clock;

   ftp_control_reply_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   reply_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending         (pending),
      .replies_checked (replies_checked),
      .pasv_seen       (pasv_seen),
      .sizes_seen      (sizes_seen),
      .overflows_seen  (overflows_seen)
   );

   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (quiet) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 8);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: no word moved for %0d cycles.", IDLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (!quiet && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 8);
         repeat (gap) @(negedge clock) req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_line(input string s);
      send_text(s);
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
   endtask

   task automatic set_limit(input logic [15:0] value);
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock) csr_we <= 1'b0;
   endtask

   function automatic string rand_text(input int n);
      string s;
      s = "";
      repeat (n) s = {s, $sformatf("%c", $urandom_range(32, 126))};
      return s;
   endfunction

   task automatic send_pasv(input bit broken);
      string g[6];
      string opener;
      string closer;
      int k;
      opener = "(";
      closer = ")";
      foreach (g[i]) g[i] = $sformatf("%0d", $urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) g[$urandom_range(0, 5)] = $sformatf("%03d", $urandom_range(0, 255));
      if (broken) begin
         k = $urandom_range(0, 5);
         case ($urandom_range(0, 5))
            0: g[k] = $sformatf("%0d", $urandom_range(256, 999));
            1: g[k] = $sformatf("%0d", $urandom_range(1000, 9999));
            2: g[k] = "";
            3: g[k] = {g[k], rand_text(1)};
            4: closer = "";
            default: opener = "";
         endcase
      end
      send_line({"227 Entering Passive Mode ", opener, g[0], ",", g[1], ",", g[2], ",", g[3],
                 ",", g[4], ",", g[5], closer, "."});
   endtask

   task automatic send_size();
      string s;
      int n;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 20) : $urandom_range(1, 8);
      s = "";
      repeat (n) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
      case ($urandom_range(0, 4))
         0: send_line({"213 ", s, " bytes"});
         1: send_line({"213 ", rand_text(1), s});
         2: send_line({"213 ", s, rand_text(2), s});
         default: send_line({"213 ", s});
      endcase
   endtask

   task automatic send_text_reply();
      int c;
      int lines;
      c     = $urandom_range(0, 999);
      lines = $urandom_range(0, 3);
      if (lines > 0) begin
         send_line($sformatf("%03d-%s", c, rand_text($urandom_range(0, 10))));
         repeat (lines - 1) begin
            if ($urandom_range(0, 1) == 0) send_line($sformatf(" %03d %s", c, rand_text(4)));
            else send_line($sformatf("%03d-%s", $urandom_range(0, 999), rand_text(3)));
         end
      end
      send_line($sformatf("%03d %s", c, rand_text($urandom_range(0, 12))));
   endtask

   task automatic send_bad_code();
      repeat (3) begin
         if ($urandom_range(0, 2) == 0) send_byte(8'($urandom_range(0, 255)));
         else send_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
      end
      send_line(" oops");
      send_line("200 ok");
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) send_byte(CHAR_CR);
      if ($urandom_range(0, 1) == 0) send_byte(CHAR_LF);
   endtask

   task automatic send_random_reply();
      case ($urandom_range(0, 12))
         0, 1, 2, 3: send_pasv(1'b0);
         4, 5:       send_pasv(1'b1);
         6, 7:       send_size();
         8, 9:       send_text_reply();
         10:         send_bad_code();
         11:         send_noise();
         default: begin
            send_text("200 a");
            send_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            send_line(rand_text($urandom_range(0, 4)));
         end
      endcase
   endtask

   initial begin
      int mark;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      send_line("227 (192,168,1,255,4,1)");
      send_line("227 (0,0,0,0,0,0)");
      send_line("227 (255,255,255,255,255,255)");
      send_line("227 (256,1,1,1,1,1)");
      send_line("227 (1,,1,1,1,1)");
      send_line("227 (1234,1,1,1,1,1)");
      send_line("227 (1,2,3,4,5,6");
      send_line("227 (1,2;3,4,5,6)");
      send_line("227 no tuple");
      send_line("213 0");
      send_line("213 281474976710655");
      send_line("213 99999999999999999999");
      send_line("213 x12");
      send_line("213 ");
      send_line("150-opening");
      send_line(" 150 still inside");
      send_line("150 done");
      send_byte(8'hFF);
      send_byte(8'h00);
      send_line("7 bad code");
      send_line("500 end");
      send_text("200 a");
      send_byte(CHAR_CR);
      send_line("b");
      send_text("200 a");
      send_byte(CHAR_LF);
      send_line("b");

      set_limit(16'd5);
      send_text("200 ");
      send_byte(CHAR_CR);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_text("123");
      set_limit(16'd6);
      send_line("200 ");

      set_limit(16'd65535);
      mark = bytes_sent;
      while (bytes_sent < mark + 100) send_random_reply();
      set_limit(16'($urandom_range(20, 60)));
      mark = bytes_sent;
      while (bytes_sent < mark + 90) send_random_reply();
      set_limit(LIMIT_RESET);
      quiet = 1'b1;
      mark = bytes_sent;
      while (bytes_sent < mark + 70) send_random_reply();

      @(negedge clock) req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d bytes; checked %0d results (%0d passive addresses, %0d sizes, %0d overflows).",
               bytes_sent, replies_checked, pasv_seen, sizes_seen, overflows_seen);
      $display("Reply limits 5, 6, 65535, a small random value and 4096 were used under random stalls.");
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/ftpr_pkg.sv
design/ftpr_tuple.sv
design/ftp_control_reply_parser.sv
design/ftpr_checker.sv
tb/reply_checker.sv
tb/testbench.sv
